FILE: hdl/block_aligned_request_splitter_macros.svh
// Assertion macros for the block-aligned request splitter checker.
// Included by the checker file; no other dependencies.
`ifndef BLOCK_ALIGNED_REQUEST_SPLITTER_MACROS_SVH
`define BLOCK_ALIGNED_REQUEST_SPLITTER_MACROS_SVH

// same-cycle implication
`define BRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("splitter check failed (same cycle)");

// next-cycle implication
`define BRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("splitter check failed (next cycle)");

`endif

FILE: hdl/brs_pkg.sv
// Shared types and constants for the block-aligned request splitter.
// No dependencies.
package brs_pkg;

   localparam int MAX_PIECES    = 64;
   localparam int IDX_W         = $clog2(MAX_PIECES);
   localparam int PIECE_INDEX_W = 6;

   localparam int OFF_W   = 32;
   localparam int SIZE_W  = 32;
   localparam int BLK_W   = 17;
   localparam int RA_W    = 5;
   localparam int POFF_W  = 33;

   localparam logic [BLK_W-1:0] BLK_MAX   = 17'd65536;
   localparam logic [BLK_W-1:0] BLK_RESET = 17'd4096;

   // remainder unit: quotient bits resolved per cycle
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = OFF_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = BLK_W;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_SIZE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_READ_AHEAD = 4'd1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // classified request, front to back
   typedef struct packed {
      logic              op;
      logic [OFF_W-1:0]  cur0;   // first piece offset
      logic [BLK_W-1:0]  first;  // first write piece size
      logic [SIZE_W-1:0] rest;   // bytes after the first piece
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

FILE: hdl/brs_rem_unit.sv
// Multi-cycle remainder unit: offset mod block size, DIV_BITS bits per cycle.
// Depends on brs_pkg.
module brs_rem_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [brs_pkg::OFF_W-1:0]  dividend,
   input  logic [brs_pkg::BLK_W-1:0]  divisor,
   output logic                       done,
   output logic [brs_pkg::BLK_W-1:0]  remainder
);
   import brs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [OFF_W-1:0]     dvd_ff, dvd_in;
   logic [BLK_W-1:0]     rem_ff, rem_in;
   logic [BLK_W-1:0]     rem_step;

   // restoring steps; partial remainder stays below divisor so 18 bits hold the shift
   always_comb begin
      logic [BLK_W:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < DIV_BITS; i++) begin
         r = {r[BLK_W-1:0], dvd_ff[OFF_W-1-i]};
         if (r >= {1'b0, divisor}) begin
            r = r - {1'b0, divisor};
         end
      end
      rem_step = r[BLK_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = dvd_ff << DIV_BITS;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/brs_front.sv
// Front end: accepts requests, finds the in-block offset and classifies them.
// Depends on brs_pkg and brs_rem_unit.
module brs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,   // request_offset[31:0], request_size[63:32]
   input  logic [0:0]                req_tuser,   // opcode[0]
   input  logic [brs_pkg::BLK_W-1:0] blk,
   input  logic                      fifo_full,
   output logic                      push,
   output brs_pkg::desc_type         push_desc
);
   import brs_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} state_type;

   state_type         state_ff;
   logic              op_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [BLK_W-1:0]  rem_ff;

   logic              accept;
   logic              div_done;
   logic [BLK_W-1:0]  div_rem;
   logic [BLK_W-1:0]  room;
   logic [BLK_W-1:0]  first;
   logic [SIZE_W-1:0] rest;
   logic [OFF_W-1:0]  base;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   brs_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_tdata[31:0]),
      .divisor   (blk),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      room  = blk - rem_ff;
      first = (size_ff < {15'b0, room}) ? size_ff[BLK_W-1:0] : room;
      rest  = size_ff - {15'b0, first};
      base  = off_ff - {15'b0, rem_ff};
   end

   assign push             = (state_ff == S_PUSH) && !fifo_full;
   assign push_desc.op     = op_ff;
   assign push_desc.cur0   = (op_ff == OP_WRITE) ? off_ff : base;
   assign push_desc.first  = first;
   assign push_desc.rest   = rest;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_tuser[0];
                  off_ff   <= req_tdata[31:0];
                  size_ff  <= req_tdata[63:32];
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  rem_ff   <= div_rem;
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (!fifo_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: hdl/brs_fifo.sv
// Short descriptor queue between front and back end.
// Depends on brs_pkg.
module brs_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  brs_pkg::desc_type         push_data,
   input  logic                      pop,
   output brs_pkg::desc_type         pop_data,
   output brs_pkg::fifo_status_type  status
);
   import brs_pkg::*;

   desc_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   cnt_ff;
   logic                    do_push;
   logic                    do_pop;

   assign status.full  = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

FILE: hdl/brs_back.sv
// Back end: emits the pieces of one classified request, one per cycle unless stalled.
// Depends on brs_pkg.
module brs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  brs_pkg::desc_type         desc,
   input  brs_pkg::fifo_status_type  fifo_status,
   output logic                      pop,
   input  logic [brs_pkg::BLK_W-1:0] blk,
   input  logic [brs_pkg::RA_W-1:0]  ahead_blocks,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [55:0]               rsp_tdata,  // piece_offset[32:0], piece_size[49:33],
                                                 // piece_index[55:50]
   output logic                      rsp_tlast,
   output logic [0:0]                rsp_tuser   // truncated[0]
);
   import brs_pkg::*;

   logic                     busy_ff;
   logic                     op_ff;
   logic [POFF_W-1:0]        cur_ff;
   logic [BLK_W-1:0]         first_ff;
   logic [SIZE_W-1:0]        rem_ff;
   logic [RA_W-1:0]          extra_ff;
   logic [IDX_W-1:0]         idx_ff;

   logic                     valid_ff;
   logic [POFF_W-1:0]        poff_ff;
   logic [BLK_W-1:0]         psize_ff;
   logic [PIECE_INDEX_W-1:0] pidx_ff;
   logic                     last_ff;
   logic                     trunc_ff;

   logic                     emit;
   logic [BLK_W-1:0]         step;
   logic [BLK_W-1:0]         e_size;
   logic [SIZE_W-1:0]        rem_in;
   logic [RA_W-1:0]          extra_in;
   logic [POFF_W-1:0]        cur_in;
   logic                     more;
   logic                     at_cap;
   logic                     e_last;
   logic [31:0]              idx_wide;

   assign pop  = !busy_ff && !fifo_status.empty;
   assign emit = busy_ff && (!valid_ff || rsp_tready);

   always_comb begin
      step = (rem_ff < {15'b0, blk}) ? rem_ff[BLK_W-1:0] : blk;
      if (idx_ff == '0) begin
         // first piece: write takes the partial head, read a whole block
         e_size   = (op_ff == OP_WRITE) ? first_ff : blk;
         rem_in   = rem_ff;
         extra_in = extra_ff;
      end else begin
         e_size   = (op_ff == OP_WRITE) ? step : blk;
         rem_in   = rem_ff - {15'b0, step};
         extra_in = (op_ff == OP_READ && rem_ff == '0) ? extra_ff - 1'b1 : extra_ff;
      end
      cur_in   = cur_ff + {16'b0, e_size};
      more     = (rem_in != '0) || (op_ff == OP_READ && extra_in != '0);
      at_cap   = (idx_ff == IDX_W'(MAX_PIECES - 1));
      e_last   = !more || at_cap;
      idx_wide = {{(32 - IDX_W){1'b0}}, idx_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (pop) begin
         busy_ff <= 1'b1;
      end else if (emit && e_last) begin
         busy_ff <= 1'b0;
      end
      if (pop) begin
         op_ff    <= desc.op;
         cur_ff   <= {1'b0, desc.cur0};
         first_ff <= desc.first;
         rem_ff   <= desc.rest;
         extra_ff <= ahead_blocks;
         idx_ff   <= '0;
      end else if (emit) begin
         cur_ff   <= cur_in;
         rem_ff   <= rem_in;
         extra_ff <= extra_in;
         idx_ff   <= idx_ff + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (emit) begin
         poff_ff  <= cur_ff;
         psize_ff <= e_size;
         pidx_ff  <= idx_wide[PIECE_INDEX_W-1:0];
         last_ff  <= e_last;
         trunc_ff <= more && at_cap;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = {pidx_ff, psize_ff, poff_ff};
   assign rsp_tlast    = last_ff;
   assign rsp_tuser[0] = trunc_ff;

endmodule

FILE: hdl/block_aligned_request_splitter.sv
// Block-aligned request splitter. A read or write request (offset, size) is cut
// at block_size boundaries: reads give whole aligned blocks plus read_ahead_blocks
// more, writes give exact byte ranges, at most MAX_PIECES pieces, truncated flagged
// on the last. The front end accepts a request, finds the in-block offset in the
// remainder unit at 4 offset bits per cycle, picks up the remainder, then
// classifies and enqueues, waiting while the queue is full; it takes no new
// request until the enqueue. The back end loads a descriptor, then emits one piece
// per cycle while rsp_tready does not hold the output. A 4-entry queue lets the
// front classify the next request while the back emits. csr_ready is always high.
// Configuration must be written only while idle; the block itself does not enforce it.
// Depends on brs_pkg, brs_front, brs_fifo, brs_back.
module block_aligned_request_splitter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [63:0]                     req_tdata,  // request_offset[31:0],
                                                       // request_size[63:32]
   input  logic [0:0]                      req_tuser,  // opcode[0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [55:0]                     rsp_tdata,  // piece_offset[32:0],
                                                       // piece_size[49:33],
                                                       // piece_index[55:50]
   output logic                            rsp_tlast,  // last
   output logic [0:0]                      rsp_tuser,  // truncated[0]
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [brs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [brs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import brs_pkg::*;

   logic [BLK_W-1:0] block_size_ff;
   logic [RA_W-1:0]  read_ahead_ff;
   logic [BLK_W-1:0] blk;

   logic             push;
   desc_type         push_desc;
   desc_type         pop_desc;
   logic             pop;
   fifo_status_type  fifo_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLK_RESET;
         read_ahead_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BLOCK_SIZE: block_size_ff <= csr_data;
            REG_READ_AHEAD: read_ahead_ff <= csr_data[RA_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, anything above 64 KiB as 64 KiB
   always_comb begin
      priority if (block_size_ff == '0) begin
         blk = BLK_W'(1);
      end else if (block_size_ff > BLK_MAX) begin
         blk = BLK_MAX;
      end else begin
         blk = block_size_ff;
      end
   end

   brs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .blk        (blk),
      .fifo_full  (fifo_status.full),
      .push       (push),
      .push_desc  (push_desc)
   );

   brs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_desc),
      .pop       (pop),
      .pop_data  (pop_desc),
      .status    (fifo_status)
   );

   brs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .desc         (pop_desc),
      .fifo_status  (fifo_status),
      .pop          (pop),
      .blk          (blk),
      .ahead_blocks (read_ahead_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

FILE: hdl/brs_checker.sv
// Port-level checks for the block-aligned request splitter, bound to the top.
// Depends on block_aligned_request_splitter_macros.svh.
`include "block_aligned_request_splitter_macros.svh"

module brs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   logic [5:0] exp_idx_ff, exp_idx_in;
   logic       rsp_xfer;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // index the next piece should carry
   always_comb begin
      exp_idx_in = exp_idx_ff;
      if (rsp_xfer) begin
         exp_idx_in = rsp_tlast ? 6'd0 : rsp_tdata[55:50] + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else begin
         exp_idx_ff <= exp_idx_in;
      end
   end

   `BRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
   `BRS_ASSERT_IMPL(a_trunc_on_last, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   `BRS_ASSERT_IMPL(a_index_seq, clock, reset, rsp_tvalid, rsp_tdata[55:50] == exp_idx_ff)
   `BRS_ASSERT_IMPL(a_empty_single, clock, reset, rsp_tvalid && rsp_tdata[49:33] == 17'd0, rsp_tlast && rsp_tdata[55:50] == 6'd0)

endmodule

bind block_aligned_request_splitter brs_checker u_brs_checker (.*);
